// ===== rtl/stream_duplicate_remover_core_macros.svh =====
// assertion macros used by the duplicate remover core
`ifndef STREAM_DUPLICATE_REMOVER_CORE_MACROS_SVH
`define STREAM_DUPLICATE_REMOVER_CORE_MACROS_SVH

// condition must hold at every clock edge out of reset
`define SDR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// same-cycle implication
`define SDR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sdr_pkg.sv =====
// types and constants of the stream duplicate remover
`default_nettype none

package sdr_pkg;

  localparam int unsigned MAX_DISTINCT = 64;
  localparam int unsigned VALUE_W      = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_item;
  } sdr_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_out;
    logic                      keep;
    logic                      overflow;
    logic                      last_out;
  } sdr_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } sdr_state_e;

endpackage

`default_nettype wire

// ===== rtl/sdr_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module sdr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/sdr_cmp.sv =====
// shared equality unit: one stored value against the search key per cycle
`default_nettype none

module sdr_cmp import sdr_pkg::*; (
  input  logic signed [VALUE_W-1:0] key_i,
  input  logic signed [VALUE_W-1:0] entry_i,
  input  logic                      entry_valid_i,
  output logic                      hit_o
);

  assign hit_o = entry_valid_i && (key_i == entry_i);

endmodule

`default_nettype wire

// ===== rtl/stream_duplicate_remover_core.sv =====
// stream duplicate remover: top level with scan sequencer and output register
// a new value is compared against every kept value, one per cycle, while a duplicate
//   ends the scan at the matching entry; the result then waits while the output stalls
// the next item is taken only after the last result is registered and the state is idle
// reset: asynchronous active low, clears state, kept count and output valid;
//   the store itself is not cleared, only entries below the kept count are read
`default_nettype none

module stream_duplicate_remover_core import sdr_pkg::*; #(
  parameter int unsigned MaxDistinct = MAX_DISTINCT
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sdr_in_t  in_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output sdr_out_t out_o,
  output logic     out_valid_o,
  input  logic     out_stall_i
);

`include "stream_duplicate_remover_core_macros.svh"

  // count holds 0 .. MaxDistinct, address only 0 .. MaxDistinct-1
  localparam int unsigned CntW  = $clog2(MaxDistinct + 1);
  localparam int unsigned AddrW = (MaxDistinct > 1) ? $clog2(MaxDistinct) : 1;

  sdr_state_e state_q, state_d;

  // current transaction being searched
  sdr_in_t item_q, item_d;

  // number of kept entries of the current set
  logic [CntW-1:0] kept_count_q, kept_count_d;

  // next entry to read, and whether last cycle issued a read
  logic [CntW-1:0] idx_q, idx_d;
  logic            rd_pend_q, rd_pend_d;
  logic            hit_q, hit_d;

  // output register parts the scan from the downstream stall
  sdr_out_t out_q, out_d;
  logic     out_valid_q, out_valid_d;

  logic                      out_free;
  logic                      ram_we;
  logic                      ram_re;
  logic signed [VALUE_W-1:0] ram_rdata;
  logic                      cmp_hit;
  logic                      store_full;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign store_full = (kept_count_q == CntW'(MaxDistinct));

  sdr_ram #(
    .Width (VALUE_W),
    .Depth (MaxDistinct),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (kept_count_q[AddrW-1:0]),
    .wdata_i (item_q.value),
    .re_i    (ram_re),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // compares the value read last cycle with the key
  sdr_cmp u_cmp (
    .key_i         (item_q.value),
    .entry_i       (ram_rdata),
    .entry_valid_i (rd_pend_q),
    .hit_o         (cmp_hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kept_count_q <= '0;
      idx_q        <= '0;
      rd_pend_q    <= 1'b0;
      hit_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      kept_count_q <= kept_count_d;
      idx_q        <= idx_d;
      rd_pend_q    <= rd_pend_d;
      hit_q        <= hit_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers need no reset
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    kept_count_d = kept_count_q;
    idx_d        = idx_q;
    rd_pend_d    = 1'b0;
    hit_d        = hit_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    in_stall_o   = 1'b1;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          item_d  = in_i;
          idx_d   = '0;
          hit_d   = 1'b0;
          state_d = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // one read issued and one compare done per cycle
        if (cmp_hit) begin
          hit_d   = 1'b1;
          state_d = ST_DONE;
        end else if (idx_q < kept_count_q) begin
          ram_re    = 1'b1;
          rd_pend_d = 1'b1;
          idx_d     = idx_q + CntW'(1);
        end else begin
          hit_d   = 1'b0;
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_d.value_out = item_q.value;
          out_d.keep      = !hit_q;
          out_d.overflow  = !hit_q && store_full;
          out_d.last_out  = item_q.last_item;
          out_valid_d     = 1'b1;
          // first occurrence goes into the store if there is room
          if (!hit_q && !store_full) begin
            ram_we       = 1'b1;
            kept_count_d = kept_count_q + CntW'(1);
          end
          // end of set empties the store
          if (item_q.last_item) begin
            kept_count_d = '0;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  // kept count never passes the store depth
  `SDR_ASSERT_ALWAYS(a_count_range, kept_count_q <= CntW'(MaxDistinct), "kept count overrun")
  // while scanning, the index stays within the kept entries
  `SDR_ASSERT_IMPL(a_idx_range, state_q == ST_SCAN, idx_q <= kept_count_q, "scan index beyond kept count")
  // an overflowed result is always a first occurrence
  `SDR_ASSERT_IMPL(a_ovf_keep, out_valid_o && out_o.overflow, out_o.keep, "overflow without keep")
  // the final item of a set leaves the store empty
  `SDR_ASSERT_NEXT(a_last_clears, (state_q == ST_DONE) && out_free && item_q.last_item,
    kept_count_q == '0, "store not emptied after last item")

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for stream_duplicate_remover_core: directed probes, random sets
`default_nettype none

module tb_top import sdr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned ITEMS_TARGET = 1850;
  localparam int unsigned SETTLE_WAIT  = MAX_DISTINCT + 16;

  // probe rows: value, last, typed, keep, overflow
  localparam int unsigned N_PROBES = 15;
  localparam logic [35:0] PROBES [N_PROBES] = '{
    {32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b0},  // single-item set right after reset
    {32'h8000_0000, 1'b0, 1'b1, 1'b1, 1'b0},  // most negative
    {32'h7fff_ffff, 1'b0, 1'b1, 1'b1, 1'b0},  // most positive
    {32'h8000_0000, 1'b0, 1'b1, 1'b0, 1'b0},  // repeat of most negative
    {32'hffff_ffff, 1'b0, 1'b1, 1'b1, 1'b0},
    {32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b0},  // zero was only kept in the previous set
    {32'h7fff_ffff, 1'b0, 1'b1, 1'b0, 1'b0},
    {32'hffff_ffff, 1'b1, 1'b1, 1'b0, 1'b0},  // repeat on the closing item
    {32'h7fff_ffff, 1'b1, 1'b1, 1'b1, 1'b0},  // store emptied, new again
    {32'h5555_5555, 1'b0, 1'b0, 1'b0, 1'b0},
    {32'haaaa_aaaa, 1'b0, 1'b0, 1'b0, 1'b0},
    {32'h5555_5554, 1'b0, 1'b0, 1'b0, 1'b0},  // differs only in the lsb
    {32'h5555_5555, 1'b0, 1'b0, 1'b0, 1'b0},
    {32'hd555_5555, 1'b0, 1'b0, 1'b0, 1'b0},  // differs only in the msb
    {32'haaaa_aaaa, 1'b1, 1'b0, 1'b0, 1'b0}
  };

  typedef struct packed {
    logic [31:0] word;
    logic        fin;
    logic        typed;
    logic        keep;
    logic        ovf;
  } probe_row_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  sdr_in_t  in_word   = '0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  sdr_out_t out_word;
  logic     out_valid;
  logic     out_stall = 1'b0;

  // predictor state: distinct words of the open set
  logic [31:0] kept_tab [MAX_DISTINCT];
  int unsigned kept_cnt = 0;

  sdr_out_t    pending_results [$];
  int unsigned snd_idle_pct = 38;
  int unsigned rcv_idle_pct = 69;
  int unsigned sent_cnt     = 0;
  int unsigned fail_cnt     = 0;
  int unsigned cycle_cnt    = 0;

  stream_duplicate_remover_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_word),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .out_o       (out_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // first-occurrence judgment; stores new words while there is room, closes the set on last
  function automatic sdr_out_t judge_first_seen(sdr_in_t w);
    sdr_out_t r;
    logic     seen;
    seen = 1'b0;
    for (int unsigned k = 0; k < kept_cnt; k++) begin
      if (kept_tab[k] == w.value) seen = 1'b1;
    end
    r.value_out = w.value;
    r.keep      = ~seen;
    r.overflow  = 1'b0;
    r.last_out  = w.last_item;
    if (!seen) begin
      if (kept_cnt < MAX_DISTINCT) begin
        kept_tab[kept_cnt] = w.value;
        kept_cnt++;
      end else begin
        r.overflow = 1'b1;
      end
    end
    if (w.last_item) kept_cnt = 0;
    return r;
  endfunction

  function automatic sdr_in_t pack_word(logic [31:0] v, logic fin);
    sdr_in_t w;
    w.value     = v;
    w.last_item = fin;
    return w;
  endfunction

  // extremes and small values come up often, the rest is full-width noise
  function automatic logic [31:0] draw_word();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4:       return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  // offer one transaction, hold it until taken, then log what it should give
  task automatic issue_word(sdr_in_t w, logic typed, sdr_out_t typed_res);
    sdr_out_t predicted;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = judge_first_seen(w);
    pending_results.push_back(typed ? typed_res : predicted);
    sent_cnt++;
  endtask

  // hold off the sender until every outstanding result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // short set drawn from a tiny pool so repeats are common
  task automatic short_set();
    logic [31:0] pool [4];
    logic [31:0] v;
    int unsigned n;
    n = $urandom_range(1, 10);
    foreach (pool[p]) pool[p] = draw_word();
    for (int unsigned i = 0; i < n; i++) begin
      v = ($urandom_range(9) < 6) ? pool[$urandom_range(3)] : draw_word();
      issue_word(pack_word(v, i == n - 1), 1'b0, '0);
    end
  endtask

  // more distinct words than the store holds, with repeats of stored and overflowed ones
  task automatic overfill_set();
    logic [31:0] distinct [$];
    logic [31:0] base;
    logic [31:0] stride;
    int unsigned n_new;
    base   = $urandom;
    stride = $urandom | 32'd1;
    n_new  = MAX_DISTINCT + $urandom_range(1, 8);
    for (int unsigned i = 0; i < n_new; i++) begin
      distinct.push_back(base + i * stride);
      issue_word(pack_word(distinct[i], 1'b0), 1'b0, '0);
      if ($urandom_range(3) == 0)
        issue_word(pack_word(distinct[$urandom_range(i)], 1'b0), 1'b0, '0);
    end
    issue_word(pack_word(distinct[$urandom_range(MAX_DISTINCT, n_new - 1)], 1'b0), 1'b0, '0);
    issue_word(pack_word(distinct[$urandom_range(MAX_DISTINCT - 1)], 1'b0), 1'b0, '0);
    issue_word(pack_word(distinct[n_new - 1], 1'b1), 1'b0, '0);
  endtask

  // result checker and receiver-side stall
  always @(posedge clk) begin
    sdr_out_t want;
    if (out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        if (fail_cnt < 10)
          $display("unexpected result: value %h keep %b ovf %b last %b",
                   out_word.value_out, out_word.keep, out_word.overflow, out_word.last_out);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_word.value_out !== want.value_out || out_word.keep !== want.keep ||
            out_word.overflow !== want.overflow || out_word.last_out !== want.last_out) begin
          if (fail_cnt < 10)
            $display("mismatch: exp value %h keep %b ovf %b last %b, got %h %b %b %b",
                     want.value_out, want.keep, want.overflow, want.last_out,
                     out_word.value_out, out_word.keep, out_word.overflow, out_word.last_out);
          fail_cnt++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < rcv_idle_pct);
  end

  initial begin
    probe_row_t  row;
    sdr_out_t    typed_res;
    int unsigned phase_end;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int unsigned phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin snd_idle_pct = 38; rcv_idle_pct = 69; end
        1:       begin snd_idle_pct = 69; rcv_idle_pct = 38; end
        default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
      endcase
      if (phase == 0) begin
        for (int unsigned i = 0; i < N_PROBES; i++) begin
          row = PROBES[i];
          typed_res.value_out = row.word;
          typed_res.keep      = row.keep;
          typed_res.overflow  = row.ovf;
          typed_res.last_out  = row.fin;
          issue_word(pack_word(row.word, row.fin), row.typed, typed_res);
        end
        overfill_set();
      end
      phase_end = N_PROBES + (ITEMS_TARGET * (phase + 1)) / 3;
      while (sent_cnt < phase_end) begin
        if ($urandom_range(19) == 0) overfill_set();
        else short_set();
      end
      drain_results();
    end

    repeat (SETTLE_WAIT) @(posedge clk);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
